// ===== rtl/jdsm_pkg.sv =====
// ----------------------------------------------------------------------------
// jdsm_pkg: shared types and constants of the joystick drive shaper and mixer
// Holds the sequencer states, the shared multiplier controls, the register
// indexes, the fixed arithmetic constants and a common saturation function.
// ----------------------------------------------------------------------------
package jdsm_pkg;

  // Configuration register indexes
  localparam logic REG_X_SCALE   = 1'b0;
  localparam logic REG_SMOOTHING = 1'b1;

  localparam logic [6:0] PCT_RESET = 7'd100;
  localparam logic [7:0] CENTRE    = 8'd127;
  localparam logic [7:0] DEADBAND_HALF = 8'd8;
  localparam logic [7:0] DRIVE_MAX = 8'd254;
  localparam logic [7:0] BYTE_MAX  = 8'd255;

  // Filter offset keeps the divided term non-negative
  localparam logic [11:0] LP_OFFSET = 12'd2000;
  localparam logic [4:0]  LP_BIAS   = 5'd20;

  // Shared multiplier widths
  localparam int MUL_A_W = 19;
  localparam int MUL_B_W = 13;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int QUO_W   = PROD_W - MUL_A_W;

  // Reciprocals scaled by 2**MUL_A_W, rounded down; one correction step fixes
  // the quotient for any dividend below 2**MUL_A_W.
  localparam logic [MUL_B_W-1:0] RECIP_100 = MUL_B_W'((1 << MUL_A_W) / 100);
  localparam logic [MUL_B_W-1:0] RECIP_127 = MUL_B_W'((1 << MUL_A_W) / 127);
  localparam logic [6:0] DIVISOR_100 = 7'd100;
  localparam logic [6:0] DIVISOR_127 = 7'd127;

  typedef enum logic {
    MUL_OP_DIRECT,
    MUL_OP_RECIP
  } mul_op_t;

  typedef enum logic {
    DIV_100,
    DIV_127
  } div_sel_t;

  typedef struct packed {
    mul_op_t  op;
    div_sel_t div;
  } mul_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SC_MUL,
    ST_SC_REC,
    ST_SC_FIX,
    ST_CV_MUL,
    ST_CV_REC,
    ST_CV_FIX,
    ST_FX_MUL,
    ST_FX_REC,
    ST_FX_FIX,
    ST_FY_MUL,
    ST_FY_REC,
    ST_FY_FIX,
    ST_DONE
  } state_t;

  // Clamp a signed value into 0..hi
  function automatic logic [7:0] sat_range(input logic signed [14:0] v,
                                           input logic [7:0] hi);
    logic [7:0] r;
    if (v < 15'sd0) begin
      r = 8'd0;
    end else if (v > $signed({7'd0, hi})) begin
      r = hi;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/jdsm_mul.sv =====
// ----------------------------------------------------------------------------
// jdsm_mul: shared multiplier with constant-divisor quotient correction
// Either multiplies the two operands, or multiplies the previous product by
// a scaled reciprocal; the corrected quotient is offered the cycle after.
// ----------------------------------------------------------------------------
module jdsm_mul
  import jdsm_pkg::*;
(
  input  logic               clk,
  input  mul_ctrl_t          ctrl,
  input  logic [MUL_A_W-1:0] op_a,
  input  logic [MUL_B_W-1:0] op_b,
  output logic [QUO_W-1:0]   quo
);

  logic [PROD_W-1:0]  prod;
  logic [MUL_A_W-1:0] a_sel;
  logic [MUL_B_W-1:0] b_sel;
  logic [MUL_A_W-1:0] num;
  logic [6:0]         divisor;
  logic [QUO_W-1:0]   q0;
  logic [MUL_A_W:0]   q0_times_d;
  logic [MUL_A_W:0]   rem;

  always_comb begin
    divisor = (ctrl.div == DIV_127) ? DIVISOR_127 : DIVISOR_100;
    if (ctrl.op == MUL_OP_RECIP) begin
      a_sel = prod[MUL_A_W-1:0];
      b_sel = (ctrl.div == DIV_127) ? RECIP_127 : RECIP_100;
    end else begin
      a_sel = op_a;
      b_sel = op_b;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a_sel) * PROD_W'(b_sel);
    if (ctrl.op == MUL_OP_RECIP) begin
      num <= prod[MUL_A_W-1:0];
    end
  end

  // The estimate is at most one short of the true quotient.
  always_comb begin
    q0         = prod[PROD_W-1:MUL_A_W];
    q0_times_d = (MUL_A_W+1)'(q0) * (MUL_A_W+1)'(divisor);
    rem        = {1'b0, num} - q0_times_d;
    quo        = (rem >= (MUL_A_W+1)'(divisor)) ? q0 + QUO_W'(1) : q0;
  end

endmodule

// ===== rtl/jdsm_mix.sv =====
// ----------------------------------------------------------------------------
// jdsm_mix: deadband removal and arcade mix
// Removes the band around centre from both filtered axes and forms the left
// and right drive commands.
// ----------------------------------------------------------------------------
module jdsm_mix
  import jdsm_pkg::*;
(
  input  logic [7:0] filt_x,
  input  logic [7:0] filt_y,
  output logic [7:0] shaped_x,
  output logic [7:0] shaped_y,
  output logic [7:0] left_drive,
  output logic [7:0] right_drive
);

  function automatic logic [7:0] deadband(input logic [7:0] v);
    logic [7:0] r;
    if (v < CENTRE - DEADBAND_HALF) begin
      r = v + DEADBAND_HALF;
    end else if (v > CENTRE + DEADBAND_HALF) begin
      r = v - DEADBAND_HALF;
    end else begin
      r = CENTRE;
    end
    return r;
  endfunction

  logic signed [14:0] sum_w;
  logic signed [14:0] diff_w;

  always_comb begin
    shaped_x    = deadband(filt_x);
    shaped_y    = deadband(filt_y);
    sum_w       = $signed({7'd0, shaped_x}) + $signed({7'd0, shaped_y})
                  - $signed({7'd0, CENTRE});
    diff_w      = $signed({7'd0, shaped_x}) - $signed({7'd0, shaped_y})
                  + $signed({7'd0, CENTRE});
    left_drive  = sat_range(sum_w, DRIVE_MAX);
    right_drive = BYTE_MAX - sat_range(diff_w, DRIVE_MAX);
  end

endmodule

// ===== rtl/joystick_drive_shaper_mixer.sv =====
// ----------------------------------------------------------------------------
// joystick_drive_shaper_mixer: joystick shaping, smoothing and arcade mix
// Sequenced datapath around one shared multiplier that also serves the
// divisions by 100 and 127 through reciprocal multiplication.
// ----------------------------------------------------------------------------
// Usage:
// A joystick sample (stick_x, stick_y) enters as a valid/ready transaction on
// the input channel. Both axes are inverted; x is scaled about centre by
// x_scale_percent and bent by a quadratic curve; both axes then pass a
// first-order low-pass with gain smoothing_percent, whose outputs are kept as
// filter state. A deadband is removed and the arcade mix gives the drive
// commands. Each input transaction yields exactly one output transaction.
// The sequencer walks four multiply/reciprocal/correct triplets through the
// one shared multiplier and takes no new sample until the last one has left
// the sequencer.
// in_ready is high only while the sequencer is idle. A finished result sits
// in the output register; the next sample can be accepted and worked on while
// it waits, and the sequencer holds in its final step until the register is
// free, so a stalled receiver throttles the input side without losing data.
// Configuration registers are written through cfg_we/cfg_index/cfg_data with
// no handshake; they must only change while the block is idle.
// Reset (synchronous, active high) sets both percentages to 100, both filter
// states to centre (127), empties the output register and idles the sequencer.
// ----------------------------------------------------------------------------
module joystick_drive_shaper_mixer
  import jdsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] stick_x,
  input  logic [7:0] stick_y,
  // output channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] shaped_x,
  output logic [7:0] shaped_y,
  output logic [7:0] left_drive,
  output logic [7:0] right_drive,
  // configuration port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [6:0] x_scale_percent;
  logic [6:0] smoothing_percent;

  // Working registers
  logic [7:0] x_inv;
  logic [7:0] y_inv;
  logic [7:0] dev_mag;
  logic       dev_neg;
  logic [7:0] curve_x;
  logic [7:0] filtered_x;
  logic [7:0] filtered_y;

  // Shared unit
  mul_ctrl_t          mul_ctrl;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [QUO_W-1:0]   mul_quo;

  // Combinational step results
  logic               x_low_side;
  logic [7:0]         scale_dev;
  logic signed [14:0] scaled_w;
  logic [7:0]         scaled;
  logic signed [14:0] curve_w;
  logic [7:0]         lp_old;
  logic [7:0]         lp_in;
  logic [11:0]        lp_term;
  logic signed [14:0] lp_w;
  logic [7:0]         lp_new;

  logic       out_load;
  logic [7:0] mix_x;
  logic [7:0] mix_y;
  logic [7:0] mix_left;
  logic [7:0] mix_right;

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_ctrl   = '{op: MUL_OP_DIRECT, div: DIV_100};
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SC_MUL;
        end
      end
      ST_SC_MUL: state_next = ST_SC_REC;
      ST_SC_REC: begin
        mul_ctrl.op = MUL_OP_RECIP;
        state_next  = ST_SC_FIX;
      end
      ST_SC_FIX: state_next = ST_CV_MUL;
      ST_CV_MUL: state_next = ST_CV_REC;
      ST_CV_REC: begin
        mul_ctrl   = '{op: MUL_OP_RECIP, div: DIV_127};
        state_next = ST_CV_FIX;
      end
      ST_CV_FIX: begin
        mul_ctrl.div = DIV_127;
        state_next   = ST_FX_MUL;
      end
      ST_FX_MUL: state_next = ST_FX_REC;
      ST_FX_REC: begin
        mul_ctrl.op = MUL_OP_RECIP;
        state_next  = ST_FX_FIX;
      end
      ST_FX_FIX: state_next = ST_FY_MUL;
      ST_FY_MUL: state_next = ST_FY_REC;
      ST_FY_REC: begin
        mul_ctrl.op = MUL_OP_RECIP;
        state_next  = ST_FY_FIX;
      end
      ST_FY_FIX: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Operand selection and step arithmetic
  // --------------------------------------------------------------------------
  always_comb begin
    // Scaling: deviation from centre on the side the inverted sample lies
    x_low_side = (x_inv < CENTRE);
    scale_dev  = x_low_side ? (CENTRE + 8'd1 - x_inv) : (x_inv - CENTRE);
    scaled_w   = x_low_side
                 ? $signed({7'd0, CENTRE}) - $signed({2'd0, mul_quo})
                 : $signed({7'd0, CENTRE}) + $signed({2'd0, mul_quo});
    scaled     = sat_range(scaled_w, BYTE_MAX);

    // Curve: the quadratic term is added below centre and taken off above
    curve_w = dev_neg
              ? $signed({7'd0, CENTRE}) + $signed({2'd0, mul_quo})
              : $signed({7'd0, CENTRE}) + 15'sd1 - $signed({2'd0, mul_quo});

    // Low-pass: the same logic serves both axes
    if (state == ST_FY_MUL || state == ST_FY_REC || state == ST_FY_FIX) begin
      lp_old = filtered_y;
      lp_in  = y_inv;
    end else begin
      lp_old = filtered_x;
      lp_in  = curve_x;
    end
    lp_term = LP_OFFSET + 12'(lp_in) - 12'(lp_old);
    lp_w    = $signed({7'd0, lp_old}) + $signed({2'd0, mul_quo})
              - $signed(15'(smoothing_percent) * 15'(LP_BIAS));
    lp_new  = sat_range(lp_w, BYTE_MAX);

    unique case (state)
      ST_SC_MUL: begin
        mul_a = MUL_A_W'(scale_dev);
        mul_b = MUL_B_W'(x_scale_percent);
      end
      ST_CV_MUL: begin
        mul_a = MUL_A_W'(dev_mag);
        mul_b = MUL_B_W'(dev_mag);
      end
      ST_FX_MUL, ST_FY_MUL: begin
        mul_a = MUL_A_W'(lp_term);
        mul_b = MUL_B_W'(smoothing_percent);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  jdsm_mul u_mul (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .op_a (mul_a),
    .op_b (mul_b),
    .quo  (mul_quo)
  );

  // --------------------------------------------------------------------------
  // Configuration, filter state and working registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale_percent   <= PCT_RESET;
      smoothing_percent <= PCT_RESET;
      filtered_x        <= CENTRE;
      filtered_y        <= CENTRE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_X_SCALE:   x_scale_percent   <= cfg_data;
          REG_SMOOTHING: smoothing_percent <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_FX_FIX) begin
        filtered_x <= lp_new;
      end
      if (state == ST_FY_FIX) begin
        filtered_y <= lp_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_inv <= ~stick_x;
      y_inv <= ~stick_y;
    end
    if (state == ST_SC_FIX) begin
      dev_neg <= (scaled < CENTRE);
      dev_mag <= (scaled < CENTRE) ? (CENTRE - scaled) : (scaled - CENTRE);
    end
    if (state == ST_CV_FIX) begin
      curve_x <= sat_range(curve_w, BYTE_MAX);
    end
  end

  // --------------------------------------------------------------------------
  // Deadband, mix and output register
  // --------------------------------------------------------------------------
  jdsm_mix u_mix (
    .filt_x      (filtered_x),
    .filt_y      (filtered_y),
    .shaped_x    (mix_x),
    .shaped_y    (mix_y),
    .left_drive  (mix_left),
    .right_drive (mix_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      shaped_x    <= mix_x;
      shaped_y    <= mix_y;
      left_drive  <= mix_left;
      right_drive <= mix_right;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fx_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FX_FIX) |=> $stable(filtered_x))
    else $error("x filter state changed outside its update step");

  a_fy_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FY_FIX) |=> $stable(filtered_y))
    else $error("y filter state changed outside its update step");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!out_valid || out_ready)) |=> out_valid && in_ready)
    else $error("finished result was not presented");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_drive != BYTE_MAX) && (right_drive != 8'd0))
    else $error("drive command outside its range");

endmodule

// ===== test/joystick_drive_shaper_mixer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_drive_shaper_mixer_tb: self-checking bench for the drive shaper
// A scripted table of samples and register writes opens the run. Randomised
// phases follow, each with fresh percentages. Every accepted sample is
// predicted by a behavioural model of the shaping chain with its own filter
// state, and each result transaction is compared field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module joystick_drive_shaper_mixer_tb;
  import jdsm_pkg::*;

  // The sender's idle bursts and the receiver's stalls are short next to the
  // sequencing of a sample, so any much longer quiet stretch means the block
  // has hung.
  localparam int WATCHDOG_LIMIT = 500;
  localparam int TAIL_CYCLES    = 32;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 92;
  localparam int SCRIPT_ROWS    = 25;

  typedef struct packed {
    logic [7:0] shaped_x;
    logic [7:0] shaped_y;
    logic [7:0] left_drive;
    logic [7:0] right_drive;
  } drive_out_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_t;

  // One row of the opening script. A write row uses sel and val. A sample
  // row uses the stick bytes, and where known is set it carries the result
  // that can be worked out by hand.
  typedef struct packed {
    row_kind_t  kind;
    logic       sel;
    logic [6:0] val;
    logic [7:0] sx;
    logic [7:0] sy;
    logic       known;
    logic [7:0] ex;
    logic [7:0] ey;
    logic [7:0] el;
    logic [7:0] er;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] stick_x = 8'd0;
  logic [7:0] stick_y = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [7:0] shaped_x;
  logic [7:0] shaped_y;
  logic [7:0] left_drive;
  logic [7:0] right_drive;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [6:0] cfg_data = 7'd0;

  // The predictor's copy of the registers and of the filter state.
  logic [6:0] x_pct;
  logic [6:0] sm_pct;
  logic [7:0] filt_x;
  logic [7:0] filt_y;

  // Predictions still waiting for their result transaction.
  drive_out_t pending_q[$];

  int  failures        = 0;
  int  samples_sent    = 0;
  int  results_checked = 0;
  int  writes_done     = 0;
  int  quiet_cycles    = 0;
  int  stall_left      = 0;
  int  idle_pct        = 30;
  bit  calm            = 1'b0;

  // At power-up the percentages are both 100, which makes the filter
  // transparent, so the first rows can be worked out by hand. Later rows are
  // left to the predictor.
  script_row_t sample_script [SCRIPT_ROWS] = '{
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd128, 8'd128, 1'b1, 8'd127, 8'd127, 8'd127, 8'd128},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd255, 8'd255, 1'b1, 8'd246, 8'd8,   8'd127, 8'd1},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd0,   8'd0,   1'b1, 8'd8,   8'd247, 8'd128, 8'd255},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd255, 8'd0,   1'b1, 8'd246, 8'd247, 8'd254, 8'd129},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd0,   8'd255, 1'b1, 8'd8,   8'd8,   8'd0,   8'd128},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd127, 8'd127, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd137, 8'd117, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd118, 8'd136, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE,  REG_X_SCALE,   7'd0,   8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE,  REG_X_SCALE,   7'd127, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd255, 8'd200, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd0,   8'd50,  1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE,  REG_SMOOTHING, 7'd0,   8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd255, 8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd0,   8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE,  REG_SMOOTHING, 7'd127, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd0,   8'd0,   1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd128, 8'd128, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE,  REG_X_SCALE,   7'd55,  8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE,  REG_SMOOTHING, 7'd37,  8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd64,  8'd192, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{ROW_SAMPLE, 1'b0, 7'd0, 8'd192, 8'd64,  1'b0, 8'd0, 8'd0, 8'd0, 8'd0}
  };

  joystick_drive_shaper_mixer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stick_x     (stick_x),
    .stick_y     (stick_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .shaped_x    (shaped_x),
    .shaped_y    (shaped_y),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int limit(input int v, input int lo, input int hi);
    int r;
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return r;
  endfunction

  // First-order low-pass. The offset keeps the divided term non-negative, so
  // truncation matches the hardware. The result saturates to a byte.
  function automatic int smooth_axis(input logic [7:0] prev, input int v);
    int g;
    int p;
    g = int'(sm_pct);
    p = int'(prev);
    return limit(p + (g * (int'(LP_OFFSET) + v - p)) / 100 - int'(LP_BIAS) * g, 0, 255);
  endfunction

  // Anything within the half-width of centre snaps to centre. Values outside
  // that band are pulled towards centre by the half-width.
  function automatic int strip_deadband(input int v);
    int c;
    int h;
    c = int'(CENTRE);
    h = int'(DEADBAND_HALF);
    return (v < c - h) ? v + h : ((v > c + h) ? v - h : c);
  endfunction

  // Works out the result of one sample and advances the filter state.
  function automatic drive_out_t predict_drive(input logic [7:0] sx, input logic [7:0] sy);
    int xi;
    int yi;
    int s;
    int bend;
    int c;
    int fx;
    int fy;
    int dx;
    int dy;
    drive_out_t r;
    xi = 255 - int'(sx);
    yi = 255 - int'(sy);
    // Scale the deflection about centre. The lower side measures from 128.
    if (xi < 127) begin
      s = 127 - (int'(x_pct) * (128 - xi)) / 100;
    end else begin
      s = 127 + (int'(x_pct) * (xi - 127)) / 100;
    end
    s = limit(s, 0, 255);
    // The quadratic bend also reverses the direction of x.
    bend = ((s - 127) * (s - 127)) / 127;
    c = limit((s < 127) ? 127 + bend : 128 - bend, 0, 255);
    fx = smooth_axis(filt_x, c);
    fy = smooth_axis(filt_y, yi);
    filt_x = 8'(fx);
    filt_y = 8'(fy);
    dx = strip_deadband(fx);
    dy = strip_deadband(fy);
    r.shaped_x    = 8'(dx);
    r.shaped_y    = 8'(dy);
    r.left_drive  = 8'(limit(dx + dy - 127, 0, 254));
    r.right_drive = 8'(255 - limit(dx - dy + 127, 0, 254));
    return r;
  endfunction

  // The extremes of the register range come up often in the random phases.
  function automatic logic [6:0] pick_percent();
    logic [6:0] v;
    case ($urandom_range(5))
      0: v = 7'd0;
      1: v = PCT_RESET;
      2: v = 7'd127;
      default: v = 7'($urandom_range(127));
    endcase
    return v;
  endfunction

  // Stick bytes are a mix of extremes, values near the deadband and the
  // full range.
  function automatic logic [7:0] pick_stick();
    logic [7:0] v;
    case ($urandom_range(9))
      0, 1: begin
        case ($urandom_range(5))
          0: v = 8'd0;
          1: v = 8'd255;
          2: v = 8'd127;
          3: v = 8'd128;
          4: v = 8'd119;
          default: v = 8'd135;
        endcase
      end
      2, 3: v = 8'(115 + $urandom_range(24));
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  // Presents one sample, optionally after a short idle burst, and holds it
  // until the transaction completes. in_valid is left high, so the next
  // sample can follow back to back.
  task automatic send_sample(input logic [7:0] sx, input logic [7:0] sy,
                             input logic known, input drive_out_t by_hand);
    drive_out_t res;
    if (!calm && ($urandom_range(99) < idle_pct)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    stick_x  <= sx;
    stick_y  <= sy;
    do @(posedge clk); while (!in_ready);
    res = predict_drive(sx, sy);
    pending_q.push_back(known ? by_hand : res);
    samples_sent++;
  endtask

  // Registers change only with the block idle: no sample is offered and
  // every predicted result has come back.
  task automatic write_reg(input logic sel, input logic [6:0] val);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_X_SCALE) begin
      x_pct = val;
    end else begin
      sm_pct = val;
    end
    writes_done++;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  // The receiver stalls in bursts at the rate set for the current phase.
  // It never stalls in the closing phase.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checking and the watchdog. Both are sampled at the rising edge,
  // so they see the values that were present before the edge.
  always @(posedge clk) begin
    drive_out_t want;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles.", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          $error("result transaction arrived with no prediction outstanding");
          failures++;
        end else begin
          want = pending_q.pop_front();
          check_field("shaped_x", want.shaped_x, shaped_x);
          check_field("shaped_y", want.shaped_y, shaped_y);
          check_field("left_drive", want.left_drive, left_drive);
          check_field("right_drive", want.right_drive, right_drive);
          results_checked++;
        end
      end
    end
  end

  initial begin
    int phase;
    int k;
    logic [6:0] xp;
    logic [6:0] sp;
    // The predictor starts from the reset state of the block.
    x_pct  = PCT_RESET;
    sm_pct = PCT_RESET;
    filt_x = CENTRE;
    filt_y = CENTRE;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Opening script: the corners of the stick, the deadband edges and both
    // registers at zero and at their 7-bit maximum.
    foreach (sample_script[i]) begin
      if (sample_script[i].kind == ROW_WRITE) begin
        write_reg(sample_script[i].sel, sample_script[i].val);
      end else begin
        send_sample(sample_script[i].sx, sample_script[i].sy, sample_script[i].known,
                    {sample_script[i].ex, sample_script[i].ey,
                     sample_script[i].el, sample_script[i].er});
      end
    end

    // Random phases. The first two pin set values: x scale at 0 and then 127,
    // smoothing at 127 and then 100. The others draw fresh settings. The
    // closing phase runs with no idling on either side.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          xp = 7'd0;
          sp = 7'd127;
        end
        1: begin
          xp = 7'd127;
          sp = PCT_RESET;
        end
        default: begin
          xp = pick_percent();
          sp = pick_percent();
        end
      endcase
      write_reg(REG_X_SCALE, xp);
      write_reg(REG_SMOOTHING, sp);
      if (phase == PHASES - 1) begin
        calm     = 1'b1;
        idle_pct = 0;
      end else begin
        idle_pct = 25 * $urandom_range(2);
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        send_sample(pick_stick(), pick_stick(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    // Keep the clock running to catch any extra result.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d joystick samples over %0d register writes; %0d results checked.",
             samples_sent, writes_done, results_checked);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
